// ===== rtl/krf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krf_pkg
// Shared types and codes of the keyed removal queue: opcodes, status codes,
// the sequencer states and the control bundle broadcast to every cell.
// ----------------------------------------------------------------------------
package krf_pkg;

   // operation codes carried in the request
   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_FIND   = 2'd3
   } krf_op_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } krf_status_type;

   // sequencer states, one-hot
   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_MATCH  = 4'b0010,
      S_SELECT = 4'b0100,
      S_EXEC   = 4'b1000
   } krf_state_type;

   // bundle broadcast from the sequencer to the row of cells
   typedef struct packed {
      logic        push_en;
      logic        shift_en;
      logic [31:0] key;
      logic [31:0] amount;
   } krf_cell_ctrl_type;

   localparam int KeyWidth    = 32;
   localparam int AmountWidth = 32;
   localparam int CountWidth  = 7;
   localparam int TotalWidth  = 48;

endpackage
`default_nettype wire

// ===== rtl/krf_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krf_cell
// One queue slot: holds a key and an amount, compares its key against the
// broadcast key, loads on push when it is the first free slot and takes its
// younger neighbor's entry when the row closes a gap.
// ----------------------------------------------------------------------------
module krf_cell #(
   parameter int CW  = 7,
   parameter int IDX = 0
) (
   input  wire logic                        clock,
   input  wire krf_pkg::krf_cell_ctrl_type  ctrl,
   input  wire logic [CW-1:0]               occ,
   input  wire logic                        shift_sel,
   input  wire logic [31:0]                 nxt_key,
   input  wire logic [31:0]                 nxt_amount,
   output logic                             match,
   output logic [31:0]                      key,
   output logic [31:0]                      amount
);
   import krf_pkg::*;

   localparam logic [CW-1:0] IdxC = CW'(IDX);

   logic [KeyWidth-1:0]    key_ff, key_in;
   logic [AmountWidth-1:0] amount_ff, amount_in;
   logic                   held;

   // slot holds an entry when it lies below the fill count
   assign held  = (occ > IdxC);
   assign match = held && (key_ff == ctrl.key);

   // shift from neighbor, or load on push into the first free slot
   always_comb begin
      key_in    = key_ff;
      amount_in = amount_ff;
      if (ctrl.shift_en && shift_sel) begin
         key_in    = nxt_key;
         amount_in = nxt_amount;
      end else if (ctrl.push_en && (occ == IdxC)) begin
         key_in    = ctrl.key;
         amount_in = ctrl.amount;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      amount_ff <= amount_in;
   end

   assign key    = key_ff;
   assign amount = amount_ff;

endmodule
`default_nettype wire

// ===== rtl/keyed_removal_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_removal_fifo
// Queue of up to DEPTH key/amount entries with push, pop, remove-by-key and
// find-by-key, built as a row of slots that shift toward the head.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one operation per transfer: opcode, key and amount.
//   rsp_* returns exactly one result per operation: status, key and amount
//   of the entry taken or found, the entry count and the running total.
//   Push and pop latch the request, then update the slots and register
//   the result. Remove and find latch the request, then every slot
//   compares its key and the match vector is registered, then the oldest
//   match is isolated and registered, then the slots close the gap and
//   the result is registered.
//   The result appears in the cycle after the update cycle and waits in the
//   output register; a new request is taken while it waits, but the update
//   cycle of that request holds until the receiver takes the old result.
//   Reset empties the queue and zeroes the total; slot contents are not
//   cleared, the fill count decides which slots hold entries. The total
//   cannot reach its saturation point for any DEPTH up to 1024.
// ----------------------------------------------------------------------------
module keyed_removal_fifo #(
   parameter int DEPTH = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [71:0]  req_tdata,   // opcode[1:0], key[33:2], amount[65:34]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata    // status[1:0], out_key[33:2],
                                          // out_amount[65:34], count[72:66],
                                          // total[120:73]
);
   import krf_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = AmountWidth + CW;
   localparam logic [CW-1:0] DepthC = CW'(DEPTH);

   krf_state_type               state_ff, state_in;
   krf_op_type                  op_ff;
   logic [KeyWidth-1:0]         key_ff;
   logic [AmountWidth-1:0]      amount_ff;
   logic [CW-1:0]               occ_ff, occ_in;
   logic [SW-1:0]               sum_ff, sum_in;
   logic [DEPTH-1:0]            match_ff, first_ff, ge_ff;
   logic [DEPTH-1:0]            match_dec;
   logic [DEPTH-1:0]            cell_match, shift_sel;
   logic [KeyWidth-1:0]         cell_key [DEPTH];
   logic [AmountWidth-1:0]      cell_amount [DEPTH];
   krf_cell_ctrl_type           ctrl;
   logic                        req_xfer, exec_go, hit;
   logic [KeyWidth-1:0]         sel_key;
   logic [AmountWidth-1:0]      sel_amount;
   krf_status_type              status_in;
   logic [KeyWidth-1:0]         out_key_in;
   logic [AmountWidth-1:0]      out_amount_in;
   logic                        rsp_valid_ff;
   logic [120:0]                rsp_data_ff;
   logic [CW+CountWidth-1:0]    count_ext;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign exec_go    = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);

   // command latch
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff     <= krf_op_type'(req_tdata[1:0]);
         key_ff    <= req_tdata[33:2];
         amount_ff <= req_tdata[65:34];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if ((req_tdata[1:0] == OP_PUSH) || (req_tdata[1:0] == OP_POP)) begin
                  state_in = S_EXEC;
               end else begin
                  state_in = S_MATCH;
               end
            end
         end
         S_MATCH:  state_in = S_SELECT;
         S_SELECT: state_in = S_EXEC;
         S_EXEC: begin
            if (exec_go) state_in = S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // match vector, oldest match and the slots at or after it
   assign match_dec = match_ff - DEPTH'(1);
   always_ff @(posedge clock) begin
      match_ff <= cell_match;
      first_ff <= match_ff & ~match_dec;
      ge_ff    <= ~(match_ff ^ match_dec) | (match_ff & ~match_dec);
   end

   // entry at the oldest match
   always_comb begin
      sel_key    = '0;
      sel_amount = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (first_ff[i]) begin
            sel_key    = sel_key | cell_key[i];
            sel_amount = sel_amount | cell_amount[i];
         end
      end
   end
   assign hit = |first_ff;

   // operation decode for the update cycle
   always_comb begin
      ctrl.push_en  = 1'b0;
      ctrl.shift_en = 1'b0;
      ctrl.key      = key_ff;
      ctrl.amount   = amount_ff;
      shift_sel     = ge_ff;
      occ_in        = occ_ff;
      sum_in        = sum_ff;
      status_in     = ST_OK;
      out_key_in    = '0;
      out_amount_in = '0;
      unique case (op_ff)
         OP_PUSH: begin
            if (occ_ff == DepthC) begin
               status_in = ST_FULL;
            end else begin
               ctrl.push_en = exec_go;
               occ_in       = occ_ff + CW'(1);
               sum_in       = sum_ff + SW'(amount_ff);
            end
         end
         OP_POP: begin
            shift_sel = '1;
            if (occ_ff == '0) begin
               status_in = ST_MISS;
            end else begin
               ctrl.shift_en = exec_go;
               occ_in        = occ_ff - CW'(1);
               sum_in        = sum_ff - SW'(cell_amount[0]);
               out_key_in    = cell_key[0];
               out_amount_in = cell_amount[0];
            end
         end
         OP_REMOVE, OP_FIND: begin
            if (!hit) begin
               status_in = ST_MISS;
            end else begin
               out_key_in    = sel_key;
               out_amount_in = sel_amount;
               if (op_ff == OP_REMOVE) begin
                  ctrl.shift_en = exec_go;
                  occ_in        = occ_ff - CW'(1);
                  sum_in        = sum_ff - SW'(sel_amount);
               end
            end
         end
         default: status_in = ST_OK;
      endcase
   end

   // fill count and running total
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         sum_ff <= '0;
      end else if (exec_go) begin
         occ_ff <= occ_in;
         sum_ff <= sum_in;
      end
   end

   // row of slots, head at index zero
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [KeyWidth-1:0]    nxt_key;
      logic [AmountWidth-1:0] nxt_amount;
      if (g < DEPTH - 1) begin : g_mid
         assign nxt_key    = cell_key[g+1];
         assign nxt_amount = cell_amount[g+1];
      end else begin : g_tail
         assign nxt_key    = cell_key[g];
         assign nxt_amount = cell_amount[g];
      end
      krf_cell #(
         .CW  (CW),
         .IDX (g)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occ        (occ_ff),
         .shift_sel  (shift_sel[g]),
         .nxt_key    (nxt_key),
         .nxt_amount (nxt_amount),
         .match      (cell_match[g]),
         .key        (cell_key[g]),
         .amount     (cell_amount[g])
      );
   end

   // result register
   assign count_ext = {{CountWidth{1'b0}}, occ_in};
   always_ff @(posedge clock) begin
      if (exec_go) begin
         rsp_data_ff <= {{(TotalWidth - SW){1'b0}}, sum_in,
                         count_ext[CountWidth-1:0], out_amount_in, out_key_in,
                         status_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_data_ff};

endmodule
`default_nettype wire

// ===== rtl/krf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krf_checker
// Port-level checks of the keyed removal queue, bound to the top level.
// ----------------------------------------------------------------------------
module krf_checker #(
   parameter int DEPTH = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [71:0]  req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [127:0] rsp_tdata
);
   import krf_pkg::*;

   // a held result stays put until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // one operation at a time: no request taken right after another
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken back to back");

   // only defined status codes
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == ST_OK) || (rsp_tdata[1:0] == ST_MISS)
                     || (rsp_tdata[1:0] == ST_FULL))
      else $error("undefined status code");

   // a failed operation returns no entry
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] != ST_OK) |-> (rsp_tdata[65:2] == '0))
      else $error("entry data on failed operation");

   // the count never exceeds the capacity
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (DEPTH > 127) || (int'(rsp_tdata[72:66]) <= DEPTH))
      else $error("count above capacity");

endmodule

bind keyed_removal_fifo krf_checker #(
   .DEPTH (DEPTH)
) u_krf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyed removal queue. A shadow copy of the
// queue predicts every result from the accepted requests; the monitor
// compares each returned transfer field by field against the oldest
// prediction. Requests arrive in bursts with random gaps, the result side
// stalls on its own changing pattern.
// ----------------------------------------------------------------------------
module tb_top;
   import krf_pkg::*;

   localparam int         DEPTH     = 64;
   localparam logic [63:0] TOTAL_MAX = 64'h0000_FFFF_FFFF_FFFF;

   // one request: operation with its key and amount
   typedef struct {
      krf_op_type  op;
      logic [31:0] key;
      logic [31:0] amount;
   } queue_op_type;

   // one result as carried on the response channel
   typedef struct {
      krf_status_type status;
      logic [31:0]    out_key;
      logic [31:0]    out_amount;
      logic [6:0]     count;
      logic [47:0]    total;
   } queue_result_type;

   // one stored entry of the shadow queue
   typedef struct {
      logic [31:0] key;
      logic [31:0] amount;
   } held_entry_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [71:0]  req_tdata  = '0;  // opcode[1:0], key[33:2], amount[65:34]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;        // status[1:0], out_key[33:2], out_amount[65:34],
                                   // count[72:66], total[120:73]

   queue_op_type     stimulus_q[$];
   queue_result_type pending_results[$];
   held_entry_type   shadow_entries[$];
   queue_op_type     req_item;
   logic [31:0]      key_pool[8];

   int stimulus_total = 0;
   int accepted_count = 0;
   int error_count    = 0;
   int burst_left     = 0;
   int gap_left       = 0;
   int ready_mode     = 0;
   int ready_left     = 0;
   int ready_phase    = 0;

   keyed_removal_fifo #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock generation
   always #5 clock = ~clock;

   // shadow queue: apply one operation and return the result it causes
   function automatic queue_result_type predict_queue_op(queue_op_type item);
      queue_result_type r;
      held_entry_type   e;
      int               pos;
      int               i;
      logic [63:0]      sum;
      r.status     = ST_OK;
      r.out_key    = '0;
      r.out_amount = '0;
      pos          = -1;
      case (item.op)
         OP_PUSH: begin
            if (shadow_entries.size() >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               e.key    = item.key;
               e.amount = item.amount;
               shadow_entries.push_back(e);
            end
         end
         OP_POP: begin
            if (shadow_entries.size() == 0) begin
               r.status = ST_MISS;
            end else begin
               r.out_key    = shadow_entries[0].key;
               r.out_amount = shadow_entries[0].amount;
               shadow_entries.pop_front();
            end
         end
         default: begin
            // oldest matching entry wins
            for (i = 0; i < shadow_entries.size() && pos < 0; i++) begin
               if (shadow_entries[i].key == item.key) pos = i;
            end
            if (pos < 0) begin
               r.status = ST_MISS;
            end else begin
               r.out_key    = shadow_entries[pos].key;
               r.out_amount = shadow_entries[pos].amount;
               if (item.op == OP_REMOVE) shadow_entries.delete(pos);
            end
         end
      endcase
      // saturating total of what is held
      sum = '0;
      for (i = 0; i < shadow_entries.size(); i++) begin
         sum = sum + {32'd0, shadow_entries[i].amount};
         if (sum > TOTAL_MAX) sum = TOTAL_MAX;
      end
      r.count = 7'(shadow_entries.size());
      r.total = sum[47:0];
      return r;
   endfunction

   task automatic add_op(input krf_op_type op, input logic [31:0] key,
                         input logic [31:0] amount);
      queue_op_type item;
      item.op     = op;
      item.key    = key;
      item.amount = amount;
      stimulus_q.push_back(item);
   endtask

   function automatic logic [31:0] pick_key();
      if ($urandom_range(99, 0) < 75) return key_pool[$urandom_range(7, 0)];
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_amount();
      int sel;
      sel = $urandom_range(9, 0);
      if (sel == 0) return 32'd0;
      if (sel == 1) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   function automatic krf_op_type pick_op(input int push_pct, input int pop_pct,
                                          input int remove_pct);
      int sel;
      sel = $urandom_range(99, 0);
      if (sel < push_pct) return OP_PUSH;
      if (sel < push_pct + pop_pct) return OP_POP;
      if (sel < push_pct + pop_pct + remove_pct) return OP_REMOVE;
      return OP_FIND;
   endfunction

   task automatic check_field(input string name, input logic [47:0] expected,
                              input logic [47:0] actual);
      if (expected !== actual) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                  $realtime, name, expected, actual);
         error_count++;
      end
   endtask

   // stimulus and end of run
   initial begin
      int          seg_len;
      int          mode;
      int          random_count;
      int          n;
      krf_op_type  op;
      key_pool[0] = 32'd0;
      key_pool[1] = 32'hFFFF_FFFF;
      for (n = 2; n < 8; n++) key_pool[n] = $urandom;

      // directed: empty queue, extremes, duplicates, middle removal, drain
      add_op(OP_POP,    32'd0,        $urandom);
      add_op(OP_FIND,   32'd0,        $urandom);
      add_op(OP_REMOVE, 32'd0,        $urandom);
      add_op(OP_PUSH,   32'd0,        32'd0);
      add_op(OP_PUSH,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_op(OP_PUSH,   key_pool[2],  32'd1);
      add_op(OP_PUSH,   key_pool[2],  32'd2);
      add_op(OP_PUSH,   key_pool[3],  32'hFFFF_FFFF);
      add_op(OP_FIND,   key_pool[2],  $urandom);
      add_op(OP_FIND,   key_pool[4],  $urandom);
      add_op(OP_REMOVE, key_pool[2],  $urandom);
      add_op(OP_FIND,   key_pool[2],  $urandom);
      add_op(OP_REMOVE, 32'hFFFF_FFFF, $urandom);
      add_op(OP_REMOVE, key_pool[4],  $urandom);
      add_op(OP_FIND,   32'd0,        $urandom);
      add_op(OP_POP,    $urandom,     $urandom);
      add_op(OP_PUSH,   32'h5555_5555, 32'hAAAA_AAAA);
      add_op(OP_PUSH,   32'hAAAA_AAAA, 32'h5555_5555);
      add_op(OP_REMOVE, key_pool[3],  $urandom);
      add_op(OP_POP,    $urandom,     $urandom);
      add_op(OP_POP,    $urandom,     $urandom);
      add_op(OP_POP,    $urandom,     $urandom);
      add_op(OP_POP,    $urandom,     $urandom);
      add_op(OP_FIND,   32'h5555_5555, $urandom);

      // fill past the top, then work at full
      for (n = 0; n < 70; n++) add_op(OP_PUSH, pick_key(), pick_amount());
      add_op(OP_FIND,   pick_key(), $urandom);
      add_op(OP_REMOVE, pick_key(), $urandom);
      add_op(OP_PUSH,   pick_key(), pick_amount());
      add_op(OP_PUSH,   pick_key(), pick_amount());
      add_op(OP_POP,    $urandom,   $urandom);
      add_op(OP_PUSH,   pick_key(), pick_amount());
      random_count = 76;

      // random segments: filling, draining or mixed
      while (random_count < 530) begin
         seg_len = $urandom_range(60, 10);
         mode    = $urandom_range(2, 0);
         for (n = 0; n < seg_len; n++) begin
            case (mode)
               0:       op = pick_op(85, 5, 5);
               1:       op = pick_op(10, 40, 40);
               default: op = pick_op(25, 25, 25);
            endcase
            add_op(op, (op == OP_POP) ? $urandom : pick_key(),
                   (op == OP_PUSH) ? pick_amount() : $urandom);
         end
         random_count += seg_len;
      end

      // drain to empty and past it
      for (n = 0; n < 70; n++) add_op(OP_POP, $urandom, $urandom);
      stimulus_total = stimulus_q.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < stimulus_total) @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (error_count == 0) begin
         $display("** keyed_removal_fifo: PASSED **");
      end else begin
         $display("** keyed_removal_fifo: FAILED **");
      end
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("** keyed_removal_fifo: FAILED **");
      $finish;
   end

   // request driver: bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = $urandom_range(24, 1);
         gap_left   = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            pending_results.push_back(predict_queue_op(req_item));
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (stimulus_q.size() != 0) begin
               req_item = stimulus_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {6'd0, req_item.amount, req_item.key, req_item.op};
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(24, 1);
                  gap_left   = ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(12, 1);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor with its own stall pattern
   always @(posedge clock) begin
      queue_result_type exp_r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $display("%0t ns: unexpected result transfer, expected none, actual %0h",
                        $realtime, rsp_tdata);
               error_count++;
            end else begin
               exp_r = pending_results.pop_front();
               check_field("status",     {46'd0, exp_r.status}, {46'd0, rsp_tdata[1:0]});
               check_field("out_key",    {16'd0, exp_r.out_key}, {16'd0, rsp_tdata[33:2]});
               check_field("out_amount", {16'd0, exp_r.out_amount},
                           {16'd0, rsp_tdata[65:34]});
               check_field("count",      {41'd0, exp_r.count}, {41'd0, rsp_tdata[72:66]});
               check_field("total",      exp_r.total, rsp_tdata[120:73]);
            end
         end
         // pick a new stall mode when the current one runs out
         if (ready_left == 0) begin
            ready_mode = $urandom_range(3, 0);
            ready_left = (ready_mode == 3) ? $urandom_range(12, 2) : $urandom_range(40, 5);
         end else begin
            ready_left--;
         end
         ready_phase++;
         case (ready_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= $urandom_range(1, 0);
            2:       rsp_tready <= (ready_phase % 4) == 0;
            default: rsp_tready <= 1'b0;
         endcase
      end
   end

endmodule

// ===== sim.f =====
rtl/krf_pkg.sv
rtl/krf_cell.sv
rtl/keyed_removal_fifo.sv
rtl/krf_checker.sv
dv/tb_top.sv
